@@ rtl/indexed_insert_delete_array_defines.svh @@
// ----------------------------------------------------------------------------
// Indexed insert/delete array: assertion macros
// Shared clocked assertion forms, disabled while reset is applied.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_DELETE_ARRAY_DEFINES_SVH
`define INDEXED_INSERT_DELETE_ARRAY_DEFINES_SVH

// check an invariant at every clock edge
`define IIDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define IIDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that an antecedent implies a consequent in the next cycle
`define IIDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/iida_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed insert/delete array: package
// Widths, operation and status codes, and the control word broadcast to cells.
// ----------------------------------------------------------------------------
package iida_pkg;

    localparam int CAPACITY = 16;
    localparam int POS_W    = 4;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SWAP   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_BADIDX = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_SWAP
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_SWAP
    } state_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   pos2;
        logic [POS_W-1:0]   sel;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  hold;
    } cell_ctl_t;

endpackage

@@ rtl/indexed_insert_delete_array.sv @@
// ----------------------------------------------------------------------------
// Indexed insert/delete array: top level
// Ordered list of signed words in a chain of cells with insert, delete,
// swap and read by index; every request yields one result.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  request   | start, busy        | kind, value_in, position, other_position
//  result    | done (one cycle)   | status, value_out, count
//
//  Insert, delete, read, failed swap: op state, then done. Valid swap adds
//  the swap state (single read bus along the cell chain, one entry per cycle).
//  A new request is taken in the cycle done is shown.
//  Reset clears the count; cell contents need no reset.
//  The receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
`include "indexed_insert_delete_array_defines.svh"

module indexed_insert_delete_array
    import iida_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  kind,
    input  logic signed [DATA_W-1:0]    value_in,
    input  logic [POS_W-1:0]            position,
    input  logic [POS_W-1:0]            other_position,
    output logic                        done,
    output logic [1:0]                  status,
    output logic signed [DATA_W-1:0]    value_out,
    output logic [CNT_W-1:0]            count
);

    state_t             state_reg,  state_next;
    kind_t              kind_reg;
    logic [DATA_W-1:0]  value_in_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos2_reg;
    logic [DATA_W-1:0]  hold_reg,   hold_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic               done_reg,   done_next;
    status_t            status_reg, status_next;
    logic [DATA_W-1:0]  result_reg, result_next;

    cell_ctl_t          ctl;
    logic [DATA_W-1:0]  entry [CAPACITY];
    logic [DATA_W-1:0]  bus   [CAPACITY+1];

    logic [CNT_W-1:0]   pos_ext;
    logic [CNT_W-1:0]   pos2_ext;

    assign pos_ext  = CNT_W'(pos_reg);
    assign pos2_ext = CNT_W'(pos2_reg);

    assign bus[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = entry[i];
        end
        else
        begin : g_mid_hi
            assign upper = entry[i+1];
        end

        iida_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .idx       (POS_W'(i)),
            .lower     (lower),
            .upper     (upper),
            .bus_in    (bus[i]),
            .read_word (bus[CAPACITY]),
            .entry     (entry[i]),
            .bus_out   (bus[i+1])
        );
    end

    always_comb
    begin
        ctl.op    = CELL_HOLD;
        ctl.pos   = pos_reg;
        ctl.pos2  = pos2_reg;
        ctl.sel   = (state_reg == ST_SWAP) ? pos2_reg : pos_reg;
        ctl.value = value_in_reg;
        ctl.hold  = hold_reg;

        if (state_reg == ST_SWAP)
            ctl.op = CELL_SWAP;
        else if (state_reg == ST_OP)
        begin
            if (kind_reg == KIND_INSERT && cnt_reg != CNT_W'(CAPACITY) && pos_ext <= cnt_reg)
                ctl.op = CELL_INSERT;
            else if (kind_reg == KIND_DELETE && pos_ext < cnt_reg)
                ctl.op = CELL_DELETE;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        hold_next   = hold_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        result_next = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_OP;
            end
            ST_OP:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                status_next = STATUS_OK;
                result_next = '0;
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                            status_next = STATUS_FULL;
                        else if (pos_ext > cnt_reg)
                            status_next = STATUS_BADIDX;
                        else
                            cnt_next = cnt_reg + 1'b1;
                    end
                    KIND_DELETE:
                    begin
                        if (pos_ext >= cnt_reg)
                            status_next = STATUS_BADIDX;
                        else
                        begin
                            result_next = bus[CAPACITY];
                            cnt_next    = cnt_reg - 1'b1;
                        end
                    end
                    KIND_SWAP:
                    begin
                        if (pos_ext >= cnt_reg || pos2_ext >= cnt_reg)
                            status_next = STATUS_BADIDX;
                        else
                        begin
                            hold_next  = bus[CAPACITY];
                            done_next  = 1'b0;
                            state_next = ST_SWAP;
                        end
                    end
                    default:
                    begin
                        if (pos_ext >= cnt_reg)
                            status_next = STATUS_BADIDX;
                        else
                            result_next = bus[CAPACITY];
                    end
                endcase
            end
            ST_SWAP:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                status_next = STATUS_OK;
                result_next = '0;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            kind_reg     <= kind_t'(kind);
            value_in_reg <= value_in;
            pos_reg      <= position;
            pos2_reg     <= other_position;
        end
        hold_reg   <= hold_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign value_out = result_reg;
    assign count     = cnt_reg;

    `IIDA_ASSERT(a_count_bound, cnt_reg <= CNT_W'(CAPACITY), "count above capacity")
    `IIDA_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "done held longer than one cycle")
    `IIDA_ASSERT_IMP(a_count_step, cnt_reg != $past(cnt_reg), $past(state_reg == ST_OP),
        "count changed outside operation cycle")
    `IIDA_ASSERT_IMP(a_fail_keeps, done_reg && status_reg != STATUS_OK,
        cnt_reg == $past(cnt_reg), "failed request changed count")

endmodule

@@ rtl/iida_cell.sv @@
// ----------------------------------------------------------------------------
// Indexed insert/delete array: storage cell
// Holds one entry, takes a neighbor's entry on a shift or a new value on an
// insert or swap, and adds its entry to the chain's read bus when selected.
// ----------------------------------------------------------------------------
module iida_cell
    import iida_pkg::*;
(
    input  logic                clk,
    input  cell_ctl_t           ctl,
    input  logic [POS_W-1:0]    idx,
    input  logic [DATA_W-1:0]   lower,
    input  logic [DATA_W-1:0]   upper,
    input  logic [DATA_W-1:0]   bus_in,
    input  logic [DATA_W-1:0]   read_word,
    output logic [DATA_W-1:0]   entry,
    output logic [DATA_W-1:0]   bus_out
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (idx == ctl.pos)
                    entry_next = ctl.value;
                else if (idx > ctl.pos)
                    entry_next = lower;
            end
            CELL_DELETE:
            begin
                if (idx >= ctl.pos)
                    entry_next = upper;
            end
            CELL_SWAP:
            begin
                if (idx == ctl.pos)
                    entry_next = read_word;
                else if (idx == ctl.pos2)
                    entry_next = ctl.hold;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign bus_out = bus_in | ((idx == ctl.sel) ? entry_reg : '0);

endmodule
